// File: sv/rbp_pkg.sv
package rbp_pkg;

  // Fixed widths of the pixel fields and the register file.
  localparam int SAMPLE_W     = 16;
  localparam int NUM_CH_PORTS = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int MODE_W       = 2;
  localparam int BSIZE_W      = 5;
  localparam int RWIDTH_W     = 13;
  localparam int CCOUNT_W     = 3;

  // Default sizing of the top level.
  localparam int MAX_BORDER_DEF = 16;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int CHANNELS_DEF   = 4;

  // Narrowest row the block pads.
  localparam int ROW_WIDTH_MIN = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_0        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_1        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_2        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_3        = 3'd7;

  // Register reset values.
  localparam logic [MODE_W-1:0]   BORDER_MODE_RST   = 2'd0;
  localparam logic [BSIZE_W-1:0]  BORDER_SIZE_RST   = 5'd1;
  localparam logic [RWIDTH_W-1:0] ROW_WIDTH_RST     = 13'd4096;
  localparam logic [CCOUNT_W-1:0] CHANNEL_COUNT_RST = 3'd1;

  // Border modes after the unused code has been folded onto constant.
  typedef enum logic [MODE_W-1:0] {
    MODE_CONST = 2'd0,
    MODE_REPL  = 2'd1,
    MODE_REFL  = 2'd2
  } mode_t;

  // Where the datapath takes the next result pixel from.
  typedef enum logic [1:0] {
    SRC_FILL = 2'd0,
    SRC_PIX  = 2'd1,
    SRC_HEAD = 2'd2,
    SRC_TAIL = 2'd3
  } src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic emit;
    logic capture;
    logic head_we;
    src_t src;
    logic is_padding;
    logic run_last;
    logic row_end;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: sv/rbp_cfg.sv
module rbp_cfg
  import rbp_pkg::*;
#(
  parameter int  MAX_BORDER = MAX_BORDER_DEF,
  parameter int  MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int  CHANNELS   = CHANNELS_DEF,
  localparam int BW         = $clog2(MAX_BORDER + 1),
  localparam int IDX_W      = $clog2(MAX_WIDTH)
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]                     cfg_index,
  input  logic [CFG_DATA_W-1:0]                    cfg_wdata,
  output mode_t                                    mode,
  output logic [BW-1:0]                            border,
  output logic [IDX_W-1:0]                         last_idx,
  output logic [CCOUNT_W-1:0]                      chans,
  output logic [NUM_CH_PORTS-1:0][SAMPLE_W-1:0]    fill
);

  logic [MODE_W-1:0]                  mode_raw_r;
  logic [BSIZE_W-1:0]                 bsize_r;
  logic [RWIDTH_W-1:0]                rwidth_r;
  logic [CCOUNT_W-1:0]                ccount_r;
  logic [NUM_CH_PORTS-1:0][SAMPLE_W-1:0] fill_r;
  logic [31:0]                        w32;
  logic [31:0]                        b32;
  logic [31:0]                        c32;

  // Writes are taken in every cycle.
  assign cfg_ready = 1'b1;

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_raw_r <= BORDER_MODE_RST;
      bsize_r    <= BORDER_SIZE_RST;
      rwidth_r   <= ROW_WIDTH_RST;
      ccount_r   <= CHANNEL_COUNT_RST;
      fill_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BORDER_MODE:   mode_raw_r <= cfg_wdata[MODE_W-1:0];
        CFG_BORDER_SIZE:   bsize_r    <= cfg_wdata[BSIZE_W-1:0];
        CFG_ROW_WIDTH:     rwidth_r   <= cfg_wdata[RWIDTH_W-1:0];
        CFG_CHANNEL_COUNT: ccount_r   <= cfg_wdata[CCOUNT_W-1:0];
        CFG_FILL_0:        fill_r[0]  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_FILL_1:        fill_r[1]  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_FILL_2:        fill_r[2]  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_FILL_3:        fill_r[3]  <= cfg_wdata[SAMPLE_W-1:0];
      endcase
    end
  end

  // Clamp width, border and channel count into their working ranges.
  // The border may never reach the row width.
  always_comb begin
    w32 = 32'(rwidth_r);
    if (w32 < 32'(ROW_WIDTH_MIN)) w32 = 32'(ROW_WIDTH_MIN);
    if (w32 > 32'(MAX_WIDTH))     w32 = 32'(MAX_WIDTH);
    b32 = 32'(bsize_r);
    if (b32 < 32'd1)              b32 = 32'd1;
    if (b32 > 32'(MAX_BORDER))    b32 = 32'(MAX_BORDER);
    if (b32 > w32 - 32'd1)        b32 = w32 - 32'd1;
    c32 = 32'(ccount_r);
    if (c32 < 32'd1)              c32 = 32'd1;
    if (c32 > 32'(CHANNELS))      c32 = 32'(CHANNELS);
  end

  assign last_idx = IDX_W'(w32 - 32'd1);
  assign border   = BW'(b32);
  assign chans    = CCOUNT_W'(c32);
  assign fill     = fill_r;

  // The unused mode code behaves as constant padding.
  always_comb begin
    unique case (mode_raw_r)
      MODE_REPL: mode = MODE_REPL;
      MODE_REFL: mode = MODE_REFL;
      default:   mode = MODE_CONST;
    endcase
  end

endmodule

// File: sv/rbp_ctrl.sv
module rbp_ctrl
  import rbp_pkg::*;
#(
  parameter int  MAX_BORDER = MAX_BORDER_DEF,
  parameter int  MAX_WIDTH  = MAX_WIDTH_DEF,
  localparam int BW         = $clog2(MAX_BORDER + 1),
  localparam int IDX_W      = $clog2(MAX_WIDTH),
  localparam int DEPTH      = MAX_BORDER + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mode_t            mode,
  input  logic [BW-1:0]    border,
  input  logic [IDX_W-1:0] last_idx,
  input  status_t          status,
  output cmd_t             cmd,
  output logic [BW-1:0]    head_waddr,
  output logic [BW-1:0]    head_raddr,
  output logic [BW-1:0]    tail_waddr,
  output logic [BW-1:0]    tail_raddr
);

  typedef enum logic [2:0] {
    S_IN,
    S_LEFT,
    S_HELD,
    S_CUR,
    S_RIGHT
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [BW-1:0]    tptr_r, tptr_nxt;
  logic [BW-1:0]    p_r, p_nxt;
  logic [BW-1:0]    head_addr_r, head_addr_nxt;
  logic [BW-1:0]    tail_addr_r, tail_addr_nxt;
  logic [BW-1:0]    tptr_inc;
  logic [BW-1:0]    tptr_dec;
  logic [BW-1:0]    tail_addr_dec;
  logic             idx_lt_b;
  logic             idx_eq_b;
  logic             at_last;
  logic             p_last;
  logic             step_done;

  // Position of the pixel in hand against border and row end.
  assign idx_lt_b = 32'(idx_r) < 32'(border);
  assign idx_eq_b = 32'(idx_r) == 32'(border);
  assign at_last  = idx_r >= last_idx;
  assign p_last   = p_r == border - BW'(1);

  // History pointers wrap at the depth of the stores.
  assign tptr_inc      = (tptr_r == BW'(DEPTH - 1)) ? '0 : tptr_r + BW'(1);
  assign tptr_dec      = (tptr_r == '0) ? BW'(DEPTH - 1) : tptr_r - BW'(1);
  assign tail_addr_dec = (tail_addr_r == '0) ? BW'(DEPTH - 1) : tail_addr_r - BW'(1);

  assign in_ready   = state_r == S_IN;
  assign head_waddr = BW'(idx_r);
  assign tail_waddr = tptr_r;
  // The stores read at the next address so the data lines up with it.
  assign head_raddr = head_addr_nxt;
  assign tail_raddr = tail_addr_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    tptr_nxt      = tptr_r;
    p_nxt         = p_r;
    head_addr_nxt = head_addr_r;
    tail_addr_nxt = tail_addr_r;
    cmd           = '0;
    cmd.src       = SRC_FILL;
    step_done     = 1'b0;

    unique case (state_r)
      S_IN: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.head_we = idx_lt_b || idx_eq_b;
          if (idx_lt_b) begin
            // Pixel is held back until the border pixel arrives.
            idx_nxt  = idx_r + IDX_W'(1);
            tptr_nxt = tptr_inc;
          end else if (idx_eq_b) begin
            state_nxt     = S_LEFT;
            p_nxt         = '0;
            head_addr_nxt = (mode == MODE_REPL) ? '0 : border;
          end else begin
            state_nxt = S_CUR;
          end
        end
      end

      S_LEFT: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.is_padding = 1'b1;
          unique case (mode)
            MODE_REPL: cmd.src = SRC_HEAD;
            MODE_REFL: begin
              // The mirror of the first border pixel is the pixel in hand.
              cmd.src       = (p_r == '0) ? SRC_PIX : SRC_HEAD;
              head_addr_nxt = head_addr_r - BW'(1);
            end
            default:   cmd.src = SRC_FILL;
          endcase
          if (p_last) begin
            state_nxt     = S_HELD;
            p_nxt         = '0;
            head_addr_nxt = '0;
          end else begin
            p_nxt = p_r + BW'(1);
          end
        end
      end

      S_HELD: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (p_r == border) begin
            cmd.src   = SRC_PIX;
            step_done = 1'b1;
          end else begin
            cmd.src       = SRC_HEAD;
            p_nxt         = p_r + BW'(1);
            head_addr_nxt = head_addr_r + BW'(1);
          end
        end
      end

      S_CUR: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.src   = SRC_PIX;
          step_done = 1'b1;
        end
      end

      S_RIGHT: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.is_padding = 1'b1;
          unique case (mode)
            MODE_REPL: cmd.src = SRC_PIX;
            MODE_REFL: begin
              cmd.src       = SRC_TAIL;
              tail_addr_nxt = tail_addr_dec;
            end
            default:   cmd.src = SRC_FILL;
          endcase
          if (p_last) begin
            cmd.row_end  = 1'b1;
            cmd.run_last = 1'b1;
            state_nxt    = S_IN;
            idx_nxt      = '0;
            tptr_nxt     = '0;
          end else begin
            p_nxt = p_r + BW'(1);
          end
        end
      end

      default: state_nxt = S_IN;
    endcase

    // After the image pixels of a beat, either pad the right side or finish.
    if (step_done) begin
      if (at_last) begin
        state_nxt     = S_RIGHT;
        p_nxt         = '0;
        tail_addr_nxt = tptr_dec;
      end else begin
        cmd.run_last = 1'b1;
        state_nxt    = S_IN;
        idx_nxt      = idx_r + IDX_W'(1);
        tptr_nxt     = tptr_inc;
      end
    end
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      idx_r       <= '0;
      tptr_r      <= '0;
      p_r         <= '0;
      head_addr_r <= '0;
      tail_addr_r <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      tptr_r      <= tptr_nxt;
      p_r         <= p_nxt;
      head_addr_r <= head_addr_nxt;
      tail_addr_r <= tail_addr_nxt;
    end
  end

  // A result is only produced when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result issued while the output register is full");

  // The end of the padded row also ends the run of the beat.
  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_end |-> (cmd.run_last && cmd.emit))
    else $error("row end without the final result of the beat");

  // After the row end the pixel position starts again from zero.
  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.row_end) |=> ((idx_r == '0) && (tptr_r == '0)))
    else $error("pixel position not cleared after row end");

  // The history write pointer stays inside the store.
  a_tptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tptr_r) < DEPTH)
    else $error("history pointer out of range");

endmodule

// File: sv/rbp_dp.sv
module rbp_dp
  import rbp_pkg::*;
#(
  parameter int  MAX_BORDER = MAX_BORDER_DEF,
  parameter int  CHANNELS   = CHANNELS_DEF,
  localparam int BW         = $clog2(MAX_BORDER + 1),
  localparam int DEPTH      = MAX_BORDER + 1,
  localparam int P_W        = CHANNELS * SAMPLE_W
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [NUM_CH_PORTS-1:0][SAMPLE_W-1:0] in_pix,
  input  logic [CCOUNT_W-1:0]                   chans,
  input  logic [NUM_CH_PORTS-1:0][SAMPLE_W-1:0] fill,
  input  cmd_t                                  cmd,
  input  logic [BW-1:0]                         head_waddr,
  input  logic [BW-1:0]                         head_raddr,
  input  logic [BW-1:0]                         tail_waddr,
  input  logic [BW-1:0]                         tail_raddr,
  output status_t                               status,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [NUM_CH_PORTS-1:0][SAMPLE_W-1:0] out_ch,
  output logic                                  out_is_padding,
  output logic                                  out_run_last,
  output logic                                  out_row_end
);

  logic [P_W-1:0]                        in_flat;
  logic [P_W-1:0]                        fill_flat;
  logic [P_W-1:0]                        pix_r;
  logic [P_W-1:0]                        head_mem [DEPTH];
  logic [P_W-1:0]                        tail_mem [DEPTH];
  logic [P_W-1:0]                        head_q_r;
  logic [P_W-1:0]                        tail_q_r;
  logic [P_W-1:0]                        sel;
  logic [NUM_CH_PORTS-1:0][SAMPLE_W-1:0] res_ch;
  logic                                  out_valid_r;
  logic [NUM_CH_PORTS-1:0][SAMPLE_W-1:0] out_ch_r;
  logic                                  out_is_padding_r;
  logic                                  out_run_last_r;
  logic                                  out_row_end_r;

  // Pack the channels in use into one pixel word; channels beyond the
  // build width are never stored.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_pack
    assign in_flat[g*SAMPLE_W +: SAMPLE_W]   = in_pix[g];
    assign fill_flat[g*SAMPLE_W +: SAMPLE_W] = fill[g];
  end

  // Pixel in hand and the two history stores, read data registered.
  always_ff @(posedge clk) begin
    head_q_r <= head_mem[head_raddr];
    tail_q_r <= tail_mem[tail_raddr];
    if (cmd.capture) begin
      pix_r                <= in_flat;
      tail_mem[tail_waddr] <= in_flat;
      if (cmd.head_we) begin
        head_mem[head_waddr] <= in_flat;
      end
    end
  end

  // Select the source of the result pixel.
  always_comb begin
    unique case (cmd.src)
      SRC_FILL: sel = fill_flat;
      SRC_PIX:  sel = pix_r;
      SRC_HEAD: sel = head_q_r;
      SRC_TAIL: sel = tail_q_r;
    endcase
  end

  // Channels outside the configured count read as zero.
  for (genvar g = 0; g < NUM_CH_PORTS; g++) begin : g_mask
    if (g < CHANNELS) begin : g_used
      assign res_ch[g] = (CCOUNT_W'(g) < chans) ? sel[g*SAMPLE_W +: SAMPLE_W] : '0;
    end else begin : g_absent
      assign res_ch[g] = '0;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch_r         <= res_ch;
      out_is_padding_r <= cmd.is_padding;
      out_run_last_r   <= cmd.run_last;
      out_row_end_r    <= cmd.row_end;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_ch          = out_ch_r;
  assign out_is_padding  = out_is_padding_r;
  assign out_run_last    = out_run_last_r;
  assign out_row_end     = out_row_end_r;

endmodule

// File: sv/image_row_border_padder_top.sv
// Flow: a held pixel is only stored, a mid-row pixel gives one result, the pixel at index
// B (the border width) releases the left border, the held pixels and itself, and the last
// pixel of the row adds the right border; the next beat is taken only after all of these.
// Results come one per cycle from the single output register while the output never stalls.
// Reset: synchronous, active low; control and registers take their reset values,
// the pixel history stores are not cleared and are written before use.
module image_row_border_padder_top
  import rbp_pkg::*;
#(
  parameter int MAX_BORDER = MAX_BORDER_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int CHANNELS   = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_pix_ch0,
  input  logic [SAMPLE_W-1:0]   in_pix_ch1,
  input  logic [SAMPLE_W-1:0]   in_pix_ch2,
  input  logic [SAMPLE_W-1:0]   in_pix_ch3,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_ch0,
  output logic [SAMPLE_W-1:0]   out_ch1,
  output logic [SAMPLE_W-1:0]   out_ch2,
  output logic [SAMPLE_W-1:0]   out_ch3,
  output logic                  out_is_padding,
  output logic                  out_run_last,
  output logic                  out_row_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BW    = $clog2(MAX_BORDER + 1);
  localparam int IDX_W = $clog2(MAX_WIDTH);

  mode_t                                 mode;
  logic [BW-1:0]                         border;
  logic [IDX_W-1:0]                      last_idx;
  logic [CCOUNT_W-1:0]                   chans;
  logic [NUM_CH_PORTS-1:0][SAMPLE_W-1:0] fill;
  logic [NUM_CH_PORTS-1:0][SAMPLE_W-1:0] in_pix;
  logic [NUM_CH_PORTS-1:0][SAMPLE_W-1:0] out_ch;
  cmd_t                                  cmd;
  status_t                               status;
  logic [BW-1:0]                         head_waddr;
  logic [BW-1:0]                         head_raddr;
  logic [BW-1:0]                         tail_waddr;
  logic [BW-1:0]                         tail_raddr;

  // Gather the channel ports of the input beat.
  assign in_pix[0] = in_pix_ch0;
  assign in_pix[1] = in_pix_ch1;
  assign in_pix[2] = in_pix_ch2;
  assign in_pix[3] = in_pix_ch3;

  // Register file and clamping of its values.
  rbp_cfg #(
    .MAX_BORDER (MAX_BORDER),
    .MAX_WIDTH  (MAX_WIDTH),
    .CHANNELS   (CHANNELS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mode      (mode),
    .border    (border),
    .last_idx  (last_idx),
    .chans     (chans),
    .fill      (fill)
  );

  // Sequencer for held pixels and border runs.
  rbp_ctrl #(
    .MAX_BORDER (MAX_BORDER),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .border     (border),
    .last_idx   (last_idx),
    .status     (status),
    .cmd        (cmd),
    .head_waddr (head_waddr),
    .head_raddr (head_raddr),
    .tail_waddr (tail_waddr),
    .tail_raddr (tail_raddr)
  );

  // Pixel stores, source selection and output register.
  rbp_dp #(
    .MAX_BORDER (MAX_BORDER),
    .CHANNELS   (CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_pix         (in_pix),
    .chans          (chans),
    .fill           (fill),
    .cmd            (cmd),
    .head_waddr     (head_waddr),
    .head_raddr     (head_raddr),
    .tail_waddr     (tail_waddr),
    .tail_raddr     (tail_raddr),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ch         (out_ch),
    .out_is_padding (out_is_padding),
    .out_run_last   (out_run_last),
    .out_row_end    (out_row_end)
  );

  assign out_ch0 = out_ch[0];
  assign out_ch1 = out_ch[1];
  assign out_ch2 = out_ch[2];
  assign out_ch3 = out_ch[3];

endmodule

// File: tb/sv/tb_image_row_border_padder_top.sv
module tb_image_row_border_padder_top;
  import rbp_pkg::*;

  localparam int HIST_DEPTH     = MAX_BORDER_DEF + 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PIXELS  = 410;
  localparam int LONG_ROW_PIXELS = 40;
  localparam int REPORT_LIMIT   = 10;

  // One padded pixel as it leaves the block.
  typedef struct packed {
    logic [SAMPLE_W-1:0] ch3;
    logic [SAMPLE_W-1:0] ch2;
    logic [SAMPLE_W-1:0] ch1;
    logic [SAMPLE_W-1:0] ch0;
    logic                is_padding;
    logic                run_last;
    logic                row_end;
  } pad_pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_pix_ch0 = '0;
  logic [SAMPLE_W-1:0]   in_pix_ch1 = '0;
  logic [SAMPLE_W-1:0]   in_pix_ch2 = '0;
  logic [SAMPLE_W-1:0]   in_pix_ch3 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SAMPLE_W-1:0]   out_ch0;
  logic [SAMPLE_W-1:0]   out_ch1;
  logic [SAMPLE_W-1:0]   out_ch2;
  logic [SAMPLE_W-1:0]   out_ch3;
  logic                  out_is_padding;
  logic                  out_run_last;
  logic                  out_row_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  image_row_border_padder_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pix_ch0     (in_pix_ch0),
    .in_pix_ch1     (in_pix_ch1),
    .in_pix_ch2     (in_pix_ch2),
    .in_pix_ch3     (in_pix_ch3),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ch0        (out_ch0),
    .out_ch1        (out_ch1),
    .out_ch2        (out_ch2),
    .out_ch3        (out_ch3),
    .out_is_padding (out_is_padding),
    .out_run_last   (out_run_last),
    .out_row_end    (out_row_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // Clock with a period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the register file, updated on each accepted write beat.
  logic [MODE_W-1:0]   reg_mode       = BORDER_MODE_RST;
  logic [BSIZE_W-1:0]  reg_border     = BORDER_SIZE_RST;
  logic [RWIDTH_W-1:0] reg_row_width  = ROW_WIDTH_RST;
  logic [CCOUNT_W-1:0] reg_chan_count = CHANNEL_COUNT_RST;
  logic [SAMPLE_W-1:0] reg_fill [NUM_CH_PORTS];

  // Row state of the padding predictor.
  int          row_pos = 0;
  logic [63:0] head_px [HIST_DEPTH];
  logic [63:0] tail_px [HIST_DEPTH];
  pad_pixel_t  staged;
  bit          staged_valid = 1'b0;

  pad_pixel_t  padded_pixels_due [$];
  logic [63:0] pending_pixels [$];
  int          pixels_queued = 0;
  int          pixels_accepted = 0;
  int          mismatch_count = 0;

  initial begin
    for (int c = 0; c < NUM_CH_PORTS; c++) begin
      reg_fill[c] = '0;
    end
  end

  // Effective row width after the out-of-range values are folded in.
  function automatic int clamp_width(int raw);
    int w;
    w = raw;
    if (w < ROW_WIDTH_MIN) w = ROW_WIDTH_MIN;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  // Unused channels read as zero.
  function automatic pad_pixel_t make_pixel(logic [63:0] px, int chans, logic pad, logic rend);
    pad_pixel_t r;
    r.ch0        = px[15:0];
    r.ch1        = (chans > 1) ? px[31:16] : '0;
    r.ch2        = (chans > 2) ? px[47:32] : '0;
    r.ch3        = (chans > 3) ? px[63:48] : '0;
    r.is_padding = pad;
    r.run_last   = 1'b0;
    r.row_end    = rend;
    return r;
  endfunction

  // The latest result is held back one step so that the last of a run can be marked.
  task automatic stage_result(pad_pixel_t r);
    if (staged_valid) padded_pixels_due.push_back(staged);
    staged       = r;
    staged_valid = 1'b1;
  endtask

  // Works out the padded pixels that one accepted input pixel releases.
  task automatic predict_padding(logic [63:0] px);
    int          w;
    int          b;
    int          chans;
    int          i;
    mode_t       mode;
    logic [63:0] src;
    logic [63:0] fill_px;
    w = clamp_width(int'(reg_row_width));
    b = int'(reg_border);
    if (b < 1) b = 1;
    if (b > MAX_BORDER_DEF) b = MAX_BORDER_DEF;
    if (b > w - 1) b = w - 1;
    chans = int'(reg_chan_count);
    if (chans < 1) chans = 1;
    if (chans > CHANNELS_DEF) chans = CHANNELS_DEF;
    if (reg_mode == MODE_REPL) mode = MODE_REPL;
    else if (reg_mode == MODE_REFL) mode = MODE_REFL;
    else mode = MODE_CONST;
    fill_px = {reg_fill[3], reg_fill[2], reg_fill[1], reg_fill[0]};
    i = row_pos;

    tail_px[i % HIST_DEPTH] = px;
    if (i <= b) head_px[i] = px;

    if (i < b) begin
      row_pos = i + 1;
    end else begin
      // Left border and the held pixels come out together once the pixel at B arrives.
      if (i == b) begin
        for (int p = 0; p < b; p++) begin
          case (mode)
            MODE_REPL: src = head_px[0];
            MODE_REFL: src = head_px[b - p];
            default:   src = fill_px;
          endcase
          stage_result(make_pixel(src, chans, 1'b1, 1'b0));
        end
        for (int p = 0; p <= b; p++) begin
          stage_result(make_pixel(head_px[p], chans, 1'b0, 1'b0));
        end
      end else begin
        stage_result(make_pixel(px, chans, 1'b0, 1'b0));
      end

      // The last pixel of the row is followed by the right border.
      if (i >= w - 1) begin
        for (int p = 0; p < b; p++) begin
          case (mode)
            MODE_REPL: src = tail_px[i % HIST_DEPTH];
            MODE_REFL: src = tail_px[(i - 1 - p) % HIST_DEPTH];
            default:   src = fill_px;
          endcase
          stage_result(make_pixel(src, chans, 1'b1, p + 1 == b));
        end
        row_pos = 0;
      end else begin
        row_pos = i + 1;
      end

      staged.run_last = 1'b1;
      padded_pixels_due.push_back(staged);
      staged_valid = 1'b0;
    end
  endtask

  task automatic note_mismatch(string what, pad_pixel_t want, pad_pixel_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%s: expected ch %h %h %h %h pad %b last %b end %b",
               what, want.ch0, want.ch1, want.ch2, want.ch3,
               want.is_padding, want.run_last, want.row_end);
      $display("    actual ch %h %h %h %h pad %b last %b end %b",
               got.ch0, got.ch1, got.ch2, got.ch3,
               got.is_padding, got.run_last, got.row_end);
    end
  endtask

  // Input driver: bursts of beats with random gaps, fed from the pending queue.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    logic [63:0] px;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_padding({in_pix_ch3, in_pix_ch2, in_pix_ch1, in_pix_ch0});
        pixels_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_pixels.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          px = pending_pixels.pop_front();
          {in_pix_ch3, in_pix_ch2, in_pix_ch1, in_pix_ch0} <= px;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Result monitor with its own stall pattern: calm stretches, short and long stalls.
  int stall_style = 0;
  int style_left = 0;
  int ready_left = 0;

  always @(posedge clk) begin
    pad_pixel_t got;
    pad_pixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_ch3, out_ch2, out_ch1, out_ch0, out_is_padding, out_run_last, out_row_end};
        if (padded_pixels_due.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = padded_pixels_due.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 2);
        style_left  = $urandom_range(100, 400);
      end else begin
        style_left--;
      end
      if (ready_left == 0) begin
        case (stall_style)
          0: begin
            out_ready  <= 1'b1;
            ready_left = 8;
          end
          1: begin
            out_ready  <= 1'($urandom_range(0, 1));
            ready_left = $urandom_range(1, 3);
          end
          default: begin
            out_ready  <= !out_ready;
            ready_left = out_ready ? $urandom_range(4, 24) : $urandom_range(1, 6);
          end
        endcase
      end else begin
        ready_left--;
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Samples lean towards the extremes now and then.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 7))
      0:       s = '0;
      1:       s = '1;
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  // Random bits above the field width, which the block must ignore.
  function automatic logic [CFG_DATA_W-1:0] with_junk(int value, int width);
    logic [CFG_DATA_W-1:0] keep;
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] v;
    keep = (16'd1 << width) - 16'd1;
    junk = CFG_DATA_W'($urandom);
    v    = CFG_DATA_W'(value);
    if ($urandom_range(0, 1) == 1) v = (junk & ~keep) | (v & keep);
    return v;
  endfunction

  task automatic queue_pixel(logic [63:0] px);
    pending_pixels.push_back(px);
    pixels_queued++;
  endtask

  task automatic queue_pixels(int count);
    for (int k = 0; k < count; k++) begin
      queue_pixel({rand_sample(), rand_sample(), rand_sample(), rand_sample()});
    end
  endtask

  // One register write beat; valid stays high so a following write can reuse it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_BORDER_MODE:   reg_mode       = data[MODE_W-1:0];
      CFG_BORDER_SIZE:   reg_border     = data[BSIZE_W-1:0];
      CFG_ROW_WIDTH:     reg_row_width  = data[RWIDTH_W-1:0];
      CFG_CHANNEL_COUNT: reg_chan_count = data[CCOUNT_W-1:0];
      CFG_FILL_0:        reg_fill[0]    = data;
      CFG_FILL_1:        reg_fill[1]    = data;
      CFG_FILL_2:        reg_fill[2]    = data;
      CFG_FILL_3:        reg_fill[3]    = data;
      default:           ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] mode, logic [15:0] bsize, logic [15:0] width,
                          logic [15:0] count, logic [15:0] f0, logic [15:0] f1,
                          logic [15:0] f2, logic [15:0] f3);
    write_reg(CFG_BORDER_MODE, mode);
    write_reg(CFG_BORDER_SIZE, bsize);
    write_reg(CFG_ROW_WIDTH, width);
    write_reg(CFG_CHANNEL_COUNT, count);
    write_reg(CFG_FILL_0, f0);
    write_reg(CFG_FILL_1, f1);
    write_reg(CFG_FILL_2, f2);
    write_reg(CFG_FILL_3, f3);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued beat is accepted and every result has come, then a little longer
  // since held pixels produce nothing to wait for.
  task automatic settle();
    while (pixels_accepted != pixels_queued || padded_pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    int random_pixels;
    int mode_raw;
    int b_raw;
    int b_eff;
    int w_raw;
    int w_eff;
    int c_raw;
    int rows;
    int count;
    random_pixels = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Narrowest row, constant fill on all four channels, extreme samples.
    set_regs(MODE_CONST, 16'd1, 16'd2, 16'd4, 16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A);
    queue_pixel('1);
    queue_pixel('0);
    settle();

    // Replicate and reflect-101 on short rows with part of the channels in use.
    set_regs(MODE_REPL, 16'd3, 16'd4, 16'd3, 16'h1234, 16'hFFFF, 16'h0001, 16'h8000);
    queue_pixels(4);
    settle();
    set_regs(MODE_REFL, 16'd2, 16'd6, 16'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_pixels(6);
    settle();

    // Unused mode, zero border, width below the minimum and zero channels, with junk above.
    set_regs(16'hFFFF, 16'hFFE0, 16'hE001, 16'hFFF8, 16'hBEEF, 16'hCAFE, 16'hFFFF, 16'h0000);
    queue_pixels(2);
    settle();

    // Border above the maximum and then limited by a row of three, too many channels.
    set_regs(MODE_REFL, 16'd20, 16'd3, 16'd7, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00);
    queue_pixels(3);
    settle();

    // Width and border saturate at their maxima; the row is left open, so the next
    // settings arrive mid-row.
    set_regs(MODE_REFL, 16'd31, 16'd8191, 16'd5, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    queue_pixels(LONG_ROW_PIXELS);
    settle();

    // Random settings, mostly short rows; a partial row leaves the next write mid-row.
    while (random_pixels < RANDOM_PIXELS) begin
      mode_raw = $urandom_range(0, 3);
      case ($urandom_range(0, 5))
        0:       b_raw = MAX_BORDER_DEF;
        1:       b_raw = $urandom_range(MAX_BORDER_DEF + 1, 31);
        2:       b_raw = 0;
        default: b_raw = $urandom_range(1, MAX_BORDER_DEF - 1);
      endcase
      b_eff = (b_raw == 0) ? 1 : (b_raw > MAX_BORDER_DEF) ? MAX_BORDER_DEF : b_raw;
      case ($urandom_range(0, 15))
        0:          w_raw = $urandom_range(0, 1);
        1:          w_raw = $urandom_range(41, 300);
        2, 3, 4, 5: w_raw = b_eff + 1;
        default:    w_raw = $urandom_range(2, 40);
      endcase
      w_eff = clamp_width(w_raw);
      c_raw = $urandom_range(0, 7);
      set_regs(with_junk(mode_raw, MODE_W), with_junk(b_raw, BSIZE_W),
               with_junk(w_raw, RWIDTH_W), with_junk(c_raw, CCOUNT_W),
               rand_sample(), rand_sample(), rand_sample(), rand_sample());
      rows  = (w_eff > 40) ? 1 : $urandom_range(1, 3);
      count = rows * w_eff;
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, w_eff - 1);
      if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;
      queue_pixels(count);
      random_pixels += count;
      settle();
    end

    if (mismatch_count == 0 && padded_pixels_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rbp_pkg.sv
sv/rbp_cfg.sv
sv/rbp_ctrl.sv
sv/rbp_dp.sv
sv/image_row_border_padder_top.sv
tb/sv/tb_image_row_border_padder_top.sv
